// File: rtl/rotary_knob_decoder_top_defines.svh
// Assertion macros for the rotary knob decoder checker.
// Expects signals named clock and reset in the scope that uses them.
`ifndef ROTARY_KNOB_DECODER_TOP_DEFINES_SVH
`define ROTARY_KNOB_DECODER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RKD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rotary knob decoder check failed");

// next-cycle implication, off during reset
`define RKD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rotary knob decoder check failed");

// holds in the cycle after reset is seen high
`define RKD_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("rotary knob decoder reset check failed");

`endif

// File: rtl/rkd_pkg.sv
// Shared types, codes and reset values for the rotary knob decoder.
// No dependencies; used by every RTL module and the checker.
package rkd_pkg;

   localparam logic [6:0]  DETENT_THRESHOLD_RST  = 7'd3;
   localparam logic [15:0] LONG_PRESS_MS_RST     = 16'd3000;
   localparam logic [15:0] MIN_CLICK_MS_RST      = 16'd50;
   localparam logic [15:0] STATUS_TIMEOUT_MS_RST = 16'd15000;

   typedef enum logic [1:0] {
      CSR_DETENT_THRESHOLD  = 2'd0,
      CSR_LONG_PRESS_MS     = 2'd1,
      CSR_MIN_CLICK_MS      = 2'd2,
      CSR_STATUS_TIMEOUT_MS = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_KNOB_CCW    = 3'd1,
      EV_KNOB_CW     = 3'd2,
      EV_PRESSED     = 3'd3,
      EV_HIDDEN_MENU = 3'd4,
      EV_CLICK       = 3'd5
   } event_code_type;

   typedef struct packed {
      logic        pin_a_level;
      logic        pin_b_level;
      logic        button_level;
      logic        button_blocked;
      logic        run_process;
      logic        press_consumed;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      event_code_type     event_code;
      logic               last_of_run;
      logic signed [31:0] knob_position;
      logic               redraw_flag;
      logic [31:0]        status_deadline_ms;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  detent_threshold;
      logic [15:0] long_press_ms;
      logic [15:0] min_click_ms;
      logic [15:0] status_timeout_ms;
   } cfg_type;

   // all results of one tick: up to three events plus the shared state fields
   typedef struct packed {
      event_code_type [2:0] events;
      logic [1:0]           last_idx;
      logic signed [31:0]   knob_position;
      logic                 redraw_flag;
      logic [31:0]          status_deadline_ms;
   } tick_type;

   // Gray-code phase step: +1 forward (0->2->3->1->0), -1 backward, else 0
   function automatic logic signed [1:0] phase_step(input logic [1:0] last_phase,
                                                    input logic [1:0] new_phase);
      logic signed [1:0] step;
      case ({last_phase, new_phase}) inside
         4'b0010, 4'b0100, 4'b1011, 4'b1101: step = 2'sd1;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: step = -2'sd1;
         default:                             step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

// File: rtl/rkd_csr.sv
// Configuration registers of the rotary knob decoder.
// Depends on rkd_pkg for the register indexes and reset values.
module rkd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rkd_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_data,
   output rkd_pkg::cfg_type      cfg
);
   import rkd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DETENT_THRESHOLD:  cfg_in.detent_threshold  = csr_data[6:0];
            CSR_LONG_PRESS_MS:     cfg_in.long_press_ms     = csr_data;
            CSR_MIN_CLICK_MS:      cfg_in.min_click_ms      = csr_data;
            CSR_STATUS_TIMEOUT_MS: cfg_in.status_timeout_ms = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detent_threshold  <= DETENT_THRESHOLD_RST;
         cfg_ff.long_press_ms     <= LONG_PRESS_MS_RST;
         cfg_ff.min_click_ms      <= MIN_CLICK_MS_RST;
         cfg_ff.status_timeout_ms <= STATUS_TIMEOUT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/rkd_core.sv
// Tick logic of the rotary knob decoder: encoder phase, detent, button and position state.
// Depends on rkd_pkg; state advances on each accepted input word.
module rkd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rkd_pkg::req_type  req_data,
   input  rkd_pkg::cfg_type  cfg,
   output rkd_pkg::tick_type tick
);
   import rkd_pkg::*;

   logic [1:0]         last_phase_ff, last_phase_in;
   logic signed [7:0]  pulse_diff_ff, pulse_diff_in;
   logic signed [15:0] detent_acc_ff, detent_acc_in;
   logic               press_active_ff, press_active_in;
   logic [31:0]        press_start_ff, press_start_in;
   logic               ignore_press_ff, ignore_press_in;
   logic signed [31:0] position_ff, position_in;
   logic               redraw_ff, redraw_in;
   logic [31:0]        deadline_ff, deadline_in;

   logic [1:0]           phase;
   logic                 button_now;
   logic signed [1:0]    step;
   logic signed [8:0]    pulse_sum;
   logic signed [7:0]    pulse_sat;
   logic signed [16:0]   acc_sum;
   logic signed [16:0]   thr;
   logic [31:0]          held;
   logic [31:0]          deadline_next;
   event_code_type [2:0] events;
   logic [1:0]           n;

   assign phase         = {~req_data.pin_b_level, ~req_data.pin_a_level};
   assign button_now    = ~req_data.button_level & ~req_data.button_blocked;
   assign step          = phase_step(last_phase_ff, phase);
   assign pulse_sum     = {pulse_diff_ff[7], pulse_diff_ff} + {{7{step[1]}}, step};
   assign acc_sum       = {detent_acc_ff[15], detent_acc_ff} + {{9{pulse_sat[7]}}, pulse_sat};
   assign thr           = {10'd0, cfg.detent_threshold};
   assign held          = req_data.now_ms - press_start_ff;
   assign deadline_next = req_data.now_ms + {16'd0, cfg.status_timeout_ms};

   always_comb begin
      if (pulse_sum > 9'sd127) begin
         pulse_sat = 8'sd127;
      end else if (pulse_sum < -9'sd128) begin
         pulse_sat = -8'sd128;
      end else begin
         pulse_sat = pulse_sum[7:0];
      end
   end

   always_comb begin
      last_phase_in   = phase;
      pulse_diff_in   = pulse_sat;
      detent_acc_in   = detent_acc_ff;
      press_active_in = press_active_ff;
      press_start_in  = press_start_ff;
      ignore_press_in = ignore_press_ff;
      position_in     = position_ff;
      redraw_in       = redraw_ff;
      deadline_in     = deadline_ff;
      events          = '{EV_NONE, EV_NONE, EV_NONE};
      n               = 2'd0;

      if (req_data.run_process) begin
         detent_acc_in = acc_sum[15:0];
         if (acc_sum > thr) begin
            events[n]     = EV_KNOB_CCW;
            n             = n + 2'd1;
            detent_acc_in = 16'sd0;
         end else if (acc_sum < -thr) begin
            events[n]     = EV_KNOB_CW;
            n             = n + 2'd1;
            detent_acc_in = 16'sd0;
         end

         if (button_now) begin
            events[n] = EV_PRESSED;
            n         = n + 2'd1;
            if (req_data.press_consumed) begin
               ignore_press_in = 1'b1;
            end
            if (!ignore_press_in) begin
               if (!press_active_ff) begin
                  press_active_in = 1'b1;
                  press_start_in  = req_data.now_ms;
               end else if (held > {16'd0, cfg.long_press_ms}) begin
                  press_active_in = 1'b0;
                  ignore_press_in = 1'b1;
                  events[n]       = EV_HIDDEN_MENU;
                  n               = n + 2'd1;
               end
            end
         end else begin
            ignore_press_in = 1'b0;
            if (press_active_ff) begin
               if (held <= {16'd0, cfg.long_press_ms} && held > {16'd0, cfg.min_click_ms}) begin
                  events[n] = EV_CLICK;
                  n         = n + 2'd1;
               end
               press_active_in = 1'b0;
            end
         end

         if (pulse_sat != 8'sd0) begin
            redraw_in     = 1'b1;
            position_in   = position_ff + {{24{pulse_sat[7]}}, pulse_sat};
            pulse_diff_in = 8'sd0;
            deadline_in   = deadline_next;
         end
         if (button_now) begin
            deadline_in = deadline_next;
         end
      end

      tick.events             = events;
      tick.last_idx           = (n == 2'd0) ? 2'd0 : n - 2'd1;
      tick.knob_position      = position_in;
      tick.redraw_flag        = redraw_in;
      tick.status_deadline_ms = deadline_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff   <= 2'd0;
         pulse_diff_ff   <= 8'sd0;
         detent_acc_ff   <= 16'sd0;
         press_active_ff <= 1'b0;
         press_start_ff  <= 32'd0;
         ignore_press_ff <= 1'b0;
         position_ff     <= 32'sd0;
         redraw_ff       <= 1'b0;
         deadline_ff     <= 32'd0;
      end else if (accept) begin
         last_phase_ff   <= last_phase_in;
         pulse_diff_ff   <= pulse_diff_in;
         detent_acc_ff   <= detent_acc_in;
         press_active_ff <= press_active_in;
         press_start_ff  <= press_start_in;
         ignore_press_ff <= ignore_press_in;
         position_ff     <= position_in;
         redraw_ff       <= redraw_in;
         deadline_ff     <= deadline_in;
      end
   end

endmodule

// File: rtl/rkd_out.sv
// Result queue of the rotary knob decoder: holds two ticks and sends their events one per word.
// Depends on rkd_pkg for the tick and result types.
module rkd_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rkd_pkg::tick_type tick,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rkd_pkg::rsp_type  rsp_data
);
   import rkd_pkg::*;

   tick_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] idx_ff, idx_in;

   tick_type head;
   logic     is_last;
   logic     send;
   logic     pop;

   assign head      = queue_ff[rd_ptr_ff];
   assign is_last   = (idx_ff == head.last_idx);
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign send      = rsp_valid & ~rsp_stall;
   assign pop       = send & is_last;

   assign rsp_data.event_code         = head.events[idx_ff];
   assign rsp_data.last_of_run        = is_last;
   assign rsp_data.knob_position      = head.knob_position;
   assign rsp_data.redraw_flag        = head.redraw_flag;
   assign rsp_data.status_deadline_ms = head.status_deadline_ms;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         idx_in = 2'd0;
      end else if (send) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         idx_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

// File: rtl/rotary_knob_decoder_top.sv
// Rotary knob decoder: one input word per tick, combinational tick logic, a two-tick result
// queue. The input side takes a word in every cycle while the queue has room; a tick's results
// are written into the queue and leave one per cycle while rsp_stall is low. A tick with n
// events (0 to 3) sends n result words, or one when n is 0. The sustained rate is one input
// word per cycle when each tick yields a single result and rsp_stall stays low. The queue
// depth of two sets when the input stalls. Registers are written via the always-ready csr port.
module rotary_knob_decoder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rkd_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rkd_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  rkd_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data
);
   import rkd_pkg::*;

   cfg_type  cfg;
   tick_type tick;
   logic     accept;
   logic     full;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   rkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rkd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg),
      .tick     (tick)
   );

   rkd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .tick      (tick),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/rkd_checker.sv
// Port-level checks for the rotary knob decoder, bound to the top level.
// Depends on rkd_pkg and the assertion macros in rotary_knob_decoder_top_defines.svh.
`include "rotary_knob_decoder_top_defines.svh"

module rkd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rkd_pkg::rsp_type rsp_data
);
   import rkd_pkg::*;

   `RKD_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `RKD_ASSERT_NEXT(run_continues, rsp_valid && !rsp_stall && !rsp_data.last_of_run, rsp_valid)
   `RKD_ASSERT_NOW(inner_has_event, rsp_valid && !rsp_data.last_of_run, rsp_data.event_code != EV_NONE)
   `RKD_ASSERT_AFTER_RESET(reset_empty, !rsp_valid)

endmodule

bind rotary_knob_decoder_top rkd_checker u_rkd_checker (.*);
